>>> src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, state codes, register indexes and line levels for the
// bit-banged I2C register-access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

  // Register reset values.
  localparam logic [15:0] PHASE_TICKS_RST = 16'd2;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  // Operation codes of a request.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Byte stage within a transaction.
  localparam logic [1:0] STG_DEV  = 2'd0;
  localparam logic [1:0] STG_REG  = 2'd1;
  localparam logic [1:0] STG_LAST = 2'd2;

  // Bus sequencer state codes.
  localparam int          ST_W        = 5;
  localparam logic [4:0]  ST_IDLE     = 5'd0;
  localparam logic [4:0]  ST_RS_PREP  = 5'd1;
  localparam logic [4:0]  ST_ST_HI1   = 5'd2;
  localparam logic [4:0]  ST_ST_HI2   = 5'd3;
  localparam logic [4:0]  ST_ST_LO1   = 5'd4;
  localparam logic [4:0]  ST_ST_LO2   = 5'd5;
  localparam logic [4:0]  ST_TX_LOW   = 5'd6;
  localparam logic [4:0]  ST_TX_HIGH  = 5'd7;
  localparam logic [4:0]  ST_TX_TAIL  = 5'd8;
  localparam logic [4:0]  ST_ACK_LOW  = 5'd9;
  localparam logic [4:0]  ST_ACK_POLL = 5'd10;
  localparam logic [4:0]  ST_RX_LOW   = 5'd11;
  localparam logic [4:0]  ST_RX_HIGH  = 5'd12;
  localparam logic [4:0]  ST_NK_LOW   = 5'd13;
  localparam logic [4:0]  ST_NK_HIGH  = 5'd14;
  localparam logic [4:0]  ST_SP_A1    = 5'd15;
  localparam logic [4:0]  ST_SP_A2    = 5'd16;
  localparam logic [4:0]  ST_SP_B1    = 5'd17;
  localparam logic [4:0]  ST_SP_B2    = 5'd18;
  localparam logic [4:0]  ST_SP_C1    = 5'd19;
  localparam logic [4:0]  ST_SP_C2    = 5'd20;
  localparam logic [4:0]  ST_COUNT    = 5'd21;

  // One input item: a bus tick, possibly carrying a request.
  typedef struct packed {
    logic       kind;
    logic [1:0] op;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } in_item_t;

  // One result item per tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       fail;
    logic [7:0] read_data;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [7:0]  ack_timeout;
  } cfg_t;

  // Sequencer state carried from tick to tick.
  typedef struct packed {
    logic [ST_W-1:0] bus_state;
    logic [15:0]     phase_count;
    logic [3:0]      bit_index;
    logic [7:0]      shift_reg;
    logic [7:0]      poll_count;
    logic [1:0]      held_op;
    logic [7:0]      held_dev;
    logic [7:0]      held_reg;
    logic [7:0]      held_data;
    logic [7:0]      rx_byte;
    logic [1:0]      byte_stage;
    logic            failed;
  } seq_state_t;

  localparam seq_state_t SEQ_STATE_RST = '{
    bus_state:   ST_IDLE,
    phase_count: 16'd0,
    bit_index:   4'd0,
    shift_reg:   8'd0,
    poll_count:  8'd0,
    held_op:     OP_WRITE,
    held_dev:    8'd0,
    held_reg:    8'd0,
    held_data:   8'd0,
    rx_byte:     8'd0,
    byte_stage:  STG_DEV,
    failed:      1'b0
  };

  // Base line levels per state: bit 1 is SCL, bit 0 is SDA.
  function automatic logic [1:0] state_level(input logic [ST_W-1:0] st);
    logic [1:0] lvl;
    lvl = 2'b11;
    case (st)
      ST_RS_PREP, ST_ACK_LOW, ST_RX_LOW, ST_NK_LOW:  lvl = 2'b01;
      ST_ST_LO1, ST_ST_LO2, ST_TX_HIGH, ST_SP_B1,
      ST_SP_B2:                                       lvl = 2'b10;
      ST_TX_LOW, ST_TX_TAIL, ST_SP_A1, ST_SP_A2:     lvl = 2'b00;
      default:                                        lvl = 2'b11;
    endcase
    return lvl;
  endfunction

endpackage

>>> src/i2cm_stream_if.sv
// ----------------------------------------------------------------------------
// i2cm_stream_if
// Valid/ready channel carrying one payload item per accepted request.
// ----------------------------------------------------------------------------
interface i2cm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/i2cm_cfg.sv
// ----------------------------------------------------------------------------
// i2cm_cfg
// Configuration register file: phase length and acknowledge timeout.
// ----------------------------------------------------------------------------
module i2cm_cfg
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index on a write.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PHASE_TICKS: cfg_nxt.phase_ticks = cfg_wdata[15:0];
        CFG_ACK_TIMEOUT: cfg_nxt.ack_timeout = cfg_wdata[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks <= PHASE_TICKS_RST;
      cfg_r.ack_timeout <= ACK_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> src/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step
// One bus tick of the sequencer: request capture, line levels, phase
// counting, bit shifting, acknowledge polling and state advance.
// ----------------------------------------------------------------------------
module i2cm_step
  import i2cm_pkg::*;
(
  input  seq_state_t state_i,
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  output seq_state_t state_o,
  output out_item_t  res_o
);

  seq_state_t  s;
  logic [15:0] q;
  logic [16:0] pc;
  logic [1:0]  lvl;
  logic        busy;
  logic        done;
  logic [7:0]  rx_shift;

  always_comb begin
    s        = state_i;
    done     = 1'b0;
    q        = (cfg_i.phase_ticks == 16'd0) ? 16'd1 : cfg_i.phase_ticks;
    rx_shift = {state_i.shift_reg[6:0], item_i.sda_in};

    // Codes outside the sequencer fall back to idle.
    if (s.bus_state >= ST_COUNT) begin
      s.bus_state = ST_IDLE;
    end

    // A request is taken only while idle; that tick opens the start condition.
    if (s.bus_state == ST_IDLE && item_i.kind && item_i.op != OP_NONE) begin
      s.held_op     = item_i.op;
      s.held_dev    = item_i.dev_addr;
      s.held_reg    = item_i.reg_addr;
      s.held_data   = item_i.wr_data;
      s.byte_stage  = STG_DEV;
      s.failed      = 1'b0;
      s.poll_count  = 8'd0;
      s.phase_count = 16'd0;
      s.bus_state   = ST_ST_HI1;
    end

    busy = (s.bus_state != ST_IDLE);
    pc   = {1'b0, s.phase_count} + 17'd1;

    // Line levels; send states put the current MSB on SDA.
    lvl = state_level(s.bus_state);
    if (s.bus_state == ST_TX_LOW || s.bus_state == ST_TX_HIGH ||
        s.bus_state == ST_TX_TAIL) begin
      lvl[0] = lvl[0] | s.shift_reg[7];
    end

    if (s.bus_state == ST_ACK_POLL) begin
      // Acknowledge poll: low SDA moves on, too many high polls fail.
      if (!item_i.sda_in) begin
        s.phase_count = 16'd0;
        if (s.held_op == OP_PROBE) begin
          s.bus_state = ST_SP_A1;
        end else if (s.byte_stage == STG_DEV) begin
          s.byte_stage = STG_REG;
          s.shift_reg  = s.held_reg;
          s.bit_index  = 4'd0;
          s.bus_state  = ST_TX_LOW;
        end else if (s.byte_stage == STG_REG) begin
          s.byte_stage = STG_LAST;
          if (s.held_op == OP_WRITE) begin
            s.shift_reg = s.held_data;
            s.bit_index = 4'd0;
            s.bus_state = ST_TX_LOW;
          end else begin
            s.bus_state = ST_RS_PREP;
          end
        end else if (s.held_op == OP_WRITE) begin
          s.bus_state = ST_SP_A1;
        end else begin
          s.shift_reg = 8'd0;
          s.bit_index = 4'd0;
          s.bus_state = ST_RX_LOW;
        end
      end else if (s.poll_count >= cfg_i.ack_timeout) begin
        s.failed      = 1'b1;
        s.phase_count = 16'd0;
        s.bus_state   = ST_SP_A1;
      end else begin
        s.poll_count = s.poll_count + 8'd1;
      end
    end else if (busy) begin
      // Timed phases advance when the phase count runs out.
      if (pc >= {1'b0, q}) begin
        s.phase_count = 16'd0;
        case (s.bus_state)
          ST_ST_LO2: begin
            s.shift_reg = (s.byte_stage == STG_DEV) ? s.held_dev : s.held_dev + 8'd1;
            s.bit_index = 4'd0;
            s.bus_state = ST_TX_LOW;
          end
          ST_TX_TAIL: begin
            s.shift_reg = {s.shift_reg[6:0], 1'b0};
            s.bit_index = s.bit_index + 4'd1;
            if (s.bit_index >= 4'd8) begin
              s.poll_count = 8'd0;
              s.bus_state  = ST_ACK_LOW;
            end else begin
              s.bus_state = ST_TX_LOW;
            end
          end
          ST_RX_HIGH: begin
            s.shift_reg = rx_shift;
            s.bit_index = s.bit_index + 4'd1;
            if (s.bit_index >= 4'd8) begin
              s.rx_byte   = rx_shift;
              s.bus_state = ST_NK_LOW;
            end else begin
              s.bus_state = ST_RX_LOW;
            end
          end
          ST_NK_HIGH: begin
            s.bus_state = ST_SP_A1;
          end
          ST_SP_C2: begin
            done        = 1'b1;
            s.bus_state = ST_IDLE;
          end
          default: begin
            s.bus_state = s.bus_state + 5'd1;
          end
        endcase
      end else begin
        s.phase_count = pc[15:0];
      end
    end
  end

  // Result of this tick.
  always_comb begin
    res_o.scl_out   = lvl[1];
    res_o.sda_out   = lvl[0];
    res_o.busy_res  = busy;
    res_o.done_res  = done;
    res_o.fail      = done & s.failed;
    res_o.read_data = s.rx_byte;
  end

  assign state_o = s;

endmodule

>>> src/i2c_master_register_access_top.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// Bit-banged I2C master for register write, register read and address probe,
// stepped one bus tick per input request.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------------------
//   in_if    | in  | valid / ready  | kind, op, dev_addr, reg_addr, wr_data, sda_in
//   out_if   | out | valid / ready  | scl_out, sda_out, busy_res, done_res, fail,
//            |     |                | read_data
//   cfg_*    | in  | write enable   | cfg_idx, cfg_wdata (16 bit)
//
// Each tick passes an input register, one pass of sequencer logic and a
// result register before its result is offered on out_if.
// One request is accepted per cycle as long as the result side keeps up; the
// sequencer state register is the only loop, closed through u_step.
// A stall on out_if holds the result register and the input register, and
// in_if.ready drops only when both are full.
// Synchronous reset clears the sequencer, valids and config, not payload data.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  i2cm_stream_if.sink           in_if,
  i2cm_stream_if.source         out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg;
  in_item_t   in_r;
  logic       in_v_r;
  logic       in_v_nxt;
  out_item_t  out_r;
  logic       out_v_r;
  logic       out_v_nxt;
  seq_state_t st_r;
  seq_state_t st_nxt;
  out_item_t  res;
  logic       in_take;
  logic       adv;

  // Configuration registers.
  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // Sequencer logic for one tick.
  i2cm_step u_step (
    .state_i (st_r),
    .item_i  (in_r),
    .cfg_i   (cfg),
    .state_o (st_nxt),
    .res_o   (res)
  );

  // Handshake: a held tick advances when the result register is free or drains.
  assign adv          = in_v_r & (~out_v_r | out_if.ready);
  assign in_if.ready  = ~in_v_r | adv;
  assign in_take      = in_if.valid & in_if.ready;
  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Pipeline valids and sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= SEQ_STATE_RST;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_if.data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  // A finished transaction is always reported as busy on its last tick.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.done_res |-> out_r.busy_res)
    else $error("done without busy");

  // Fail is only raised together with done.
  a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.fail |-> out_r.done_res)
    else $error("fail without done");

  // An idle sequencer holds no pending phase count.
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bus_state == ST_IDLE |-> st_r.phase_count == 16'd0)
    else $error("phase count left over in idle");

  // Bit counter never runs past one byte.
  a_bit_index: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bit_index <= 4'd8)
    else $error("bit index out of range");

  // An advancing tick always lands in the result register.
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("result lost");

endmodule
